// ===== rtl/i2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_pkg: shared types and constants for the integer to decimal text block
// Widths of the fields, character codes and the records passed between the
// front queue, the binary to BCD converter and the character emitter.
// ----------------------------------------------------------------------------
package i2d_pkg;

   localparam int NumW      = 64;
   localparam int DigitsMax = 20;
   localparam int DigitW    = 4;
   localparam int IdxW      = $clog2(DigitsMax);
   localparam int CharW     = 6;
   localparam int LenW      = 5;
   localparam int StepsPerCycle = 2;
   localparam int ConvCycles    = NumW / StepsPerCycle;
   localparam int CntW          = $clog2(ConvCycles);

   localparam logic [CharW-1:0] ChMinus = 6'd45;
   localparam logic [CharW-1:0] ChZero  = 6'd48;

   localparam logic FuncUnsigned = 1'b0;
   localparam logic FuncSigned   = 1'b1;

   typedef logic [DigitsMax-1:0][DigitW-1:0] dig_vec_type;

   // A classified number waiting for conversion.
   typedef struct packed {
      logic            neg;
      logic [NumW-1:0] mag;
   } job_type;

   // A converted number waiting for emission.
   typedef struct packed {
      logic        neg;
      dig_vec_type digits;
   } bcd_type;

endpackage

// ===== rtl/i2d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_front: input classification and job queue
// Decides sign and magnitude of each accepted word and holds up to two jobs
// for the converter.
// ----------------------------------------------------------------------------
module i2d_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_func,
   input  logic [i2d_pkg::NumW-1:0] in_number,
   output logic                    job_valid,
   input  logic                    job_ready,
   output i2d_pkg::job_type        job
);
   import i2d_pkg::*;

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   job_type    entry;

   assign in_ready  = (cnt_ff != 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = job_valid && job_ready;

   always_comb begin
      entry.neg = (in_func == FuncSigned) && in_number[NumW-1];
      // Unsigned negation also covers the most negative value.
      entry.mag = entry.neg ? (NumW'(0) - in_number) : in_number;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/i2d_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_conv: binary to BCD converter
// Shift-and-add-three conversion of the magnitude, two bits per cycle.
// ----------------------------------------------------------------------------
module i2d_conv (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  i2d_pkg::job_type job,
   output logic             bcd_valid,
   input  logic             bcd_ready,
   output i2d_pkg::bcd_type bcd
);
   import i2d_pkg::*;

   typedef enum logic [1:0] {IDLE, RUN, DONE} state_type;

   state_type       state_ff;
   logic [CntW-1:0] cnt_ff;
   logic [NumW-1:0] mag_ff;
   logic            neg_ff;
   dig_vec_type     dig_ff;
   dig_vec_type     dig_in;

   function automatic dig_vec_type dd_shift(dig_vec_type d, logic b);
      dig_vec_type                  a;
      logic [DigitsMax*DigitW-1:0] flat;
      for (int i = 0; i < DigitsMax; i++) begin
         a[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
      end
      flat = a;
      flat = {flat[DigitsMax*DigitW-2:0], b};
      return dig_vec_type'(flat);
   endfunction

   assign job_ready  = (state_ff == IDLE);
   assign bcd_valid  = (state_ff == DONE);
   assign bcd.neg    = neg_ff;
   assign bcd.digits = dig_ff;

   always_comb begin
      dig_in = dig_ff;
      for (int s = 0; s < StepsPerCycle; s++) begin
         dig_in = dd_shift(dig_in, mag_ff[NumW-1-s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  state_ff <= RUN;
                  cnt_ff   <= CntW'(ConvCycles - 1);
                  neg_ff   <= job.neg;
                  mag_ff   <= job.mag;
                  dig_ff   <= '0;
               end
            end
            RUN: begin
               dig_ff <= dig_in;
               mag_ff <= mag_ff << StepsPerCycle;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (bcd_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/i2d_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_emit: character emitter
// Drops leading zeros and sends the sign and digits one character per beat
// through a registered output stage.
// ----------------------------------------------------------------------------
module i2d_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      bcd_valid,
   output logic                      bcd_ready,
   input  i2d_pkg::bcd_type          bcd,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [i2d_pkg::CharW-1:0] out_char,
   output logic [i2d_pkg::LenW-1:0]  out_len,
   output logic                      out_last
);
   import i2d_pkg::*;

   logic              busy_ff;
   logic              sign_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [LenW-1:0]   len_ff;
   dig_vec_type       dig_ff;
   logic              valid_ff;
   logic [CharW-1:0]  char_ff;
   logic [LenW-1:0]   olen_ff;
   logic              last_ff;
   logic [IdxW-1:0]   top_idx;
   logic              load_out;

   assign bcd_ready = !busy_ff;
   assign load_out  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_len   = olen_ff;
   assign out_last  = last_ff;

   // Position of the most significant nonzero digit; zero keeps one digit.
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < DigitsMax; i++) begin
         if (bcd.digits[i] != '0) begin
            top_idx = IdxW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (!busy_ff) begin
            if (bcd_valid) begin
               busy_ff <= 1'b1;
               sign_ff <= bcd.neg;
               idx_ff  <= top_idx;
               dig_ff  <= bcd.digits;
               len_ff  <= LenW'(top_idx) + LenW'(1) + LenW'(bcd.neg);
            end
            if (out_ready) begin
               valid_ff <= 1'b0;
            end
         end else if (load_out) begin
            valid_ff <= 1'b1;
            olen_ff  <= len_ff;
            if (sign_ff) begin
               char_ff <= ChMinus;
               last_ff <= 1'b0;
               sign_ff <= 1'b0;
            end else begin
               char_ff <= ChZero + CharW'(dig_ff[idx_ff]);
               last_ff <= (idx_ff == '0);
               if (idx_ff == '0) begin
                  busy_ff <= 1'b0;
               end else begin
                  idx_ff <= idx_ff - 1'b1;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/int64_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: 64-bit word to decimal ASCII text
// Converts each input word into its decimal text, sent one character per beat.
// ----------------------------------------------------------------------------
// A word enters with req_tuser selecting unsigned (0) or signed (1) reading.
// Its text leaves most significant character first, a '-' ahead of negative
// values, no leading zeros, every beat carrying the total length, tlast on
// the final character. The binary to BCD unit converts a word by shifting two
// bits of the magnitude per cycle; emission of a word's 1 to 20 characters
// overlaps conversion of the next word. Two words can wait in the input
// queue while the converter is busy.
module int64_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] number
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] text_char, [10:6] text_length, zero pad
   output logic        rsp_tlast    // last_char
);
   import i2d_pkg::*;

   logic             job_valid, job_ready;
   job_type          job;
   logic             bcd_valid, bcd_ready;
   bcd_type          bcd;
   logic [CharW-1:0] text_char;
   logic [LenW-1:0]  text_length;

   i2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_number (req_tdata),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   i2d_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .bcd_valid (bcd_valid),
      .bcd_ready (bcd_ready),
      .bcd       (bcd)
   );

   i2d_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .bcd_valid (bcd_valid),
      .bcd_ready (bcd_ready),
      .bcd       (bcd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (text_char),
      .out_len   (text_length),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, text_length, text_char};

   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (text_char == ChMinus) ||
                     ((text_char >= ChZero) && (text_char <= ChZero + 6'd9)))
      else $error("character is neither a sign nor a digit");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (text_length >= 5'd1) && (text_length <= 5'd20))
      else $error("text length out of range");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (text_char == ChMinus) |-> !rsp_tlast && (text_length >= 5'd2))
      else $error("sign character ends the text");

   a_single_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (text_length == 5'd1) |-> rsp_tlast && (text_char != ChMinus))
      else $error("one-character text is not a final digit");

endmodule
